[rtl/thermistor_ohms_to_temp_interp_core_defines.svh]
// Assertion macros shared by the thermistor converter RTL.
`ifndef THERMISTOR_OHMS_TO_TEMP_INTERP_CORE_DEFINES_SVH
`define THERMISTOR_OHMS_TO_TEMP_INTERP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define THTEMP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define THTEMP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/thtemp_pkg.sv]
// Shared constants, table functions and types of the thermistor converter.
package thtemp_pkg;

	localparam int OHMS_W = 16;
	localparam int TEMP_W = 13;
	localparam int DEG_W = 9;
	localparam int MAG_W = 12;
	localparam int PROD_W = OHMS_W + MAG_W;
	localparam int TABLE_CAP = 64;
	localparam int SEG_W = $clog2(TABLE_CAP);
	localparam int TABLE_POINTS_DEF = 17;
	localparam int FAULT_OFFSET = 1600;
	localparam int TEMP_HI = 2 ** (TEMP_W - 1) - 1;
	localparam int TEMP_LO = -(2 ** (TEMP_W - 1));

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP = 2'd2;

	localparam logic [OHMS_W-1:0] RST_VALID_MIN = 16'd40;
	localparam logic [OHMS_W-1:0] RST_VALID_MAX = 16'd30000;
	localparam logic signed [TEMP_W-1:0] RST_MIN_TEMP = -13'sd640;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};

	// Table resistance points, falling; points past the given ones read zero.
	function automatic logic [OHMS_W-1:0] tbl_ohms(input logic [SEG_W-1:0] idx);
		logic [OHMS_W-1:0] v;
		case (idx)
			6'd0: v = 16'd28146;
			6'd1: v = 16'd15873;
			6'd2: v = 16'd9256;
			6'd3: v = 16'd5572;
			6'd4: v = 16'd3457;
			6'd5: v = 16'd2830;
			6'd6: v = 16'd1443;
			6'd7: v = 16'd992;
			6'd8: v = 16'd660;
			6'd9: v = 16'd475;
			6'd10: v = 16'd329;
			6'd11: v = 16'd244;
			6'd12: v = 16'd175;
			6'd13: v = 16'd134;
			6'd14: v = 16'd99;
			6'd15: v = 16'd60;
			6'd16: v = 16'd47;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Table temperature points in whole degrees C.
	function automatic logic signed [DEG_W-1:0] tbl_deg(input logic [SEG_W-1:0] idx);
		logic signed [DEG_W-1:0] v;
		case (idx)
			6'd0: v = -9'sd20;
			6'd1: v = -9'sd10;
			6'd2: v = 9'sd0;
			6'd3: v = 9'sd10;
			6'd4: v = 9'sd20;
			6'd5: v = 9'sd30;
			6'd6: v = 9'sd40;
			6'd7: v = 9'sd50;
			6'd8: v = 9'sd60;
			6'd9: v = 9'sd70;
			6'd10: v = 9'sd80;
			6'd11: v = 9'sd90;
			6'd12: v = 9'sd100;
			6'd13: v = 9'sd110;
			6'd14: v = 9'sd120;
			6'd15: v = 9'sd140;
			6'd16: v = 9'sd160;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Table temperature in 1/16 degree units.
	function automatic logic signed [TEMP_W-1:0] deg16(input logic [SEG_W-1:0] idx);
		return signed'(TEMP_W'({tbl_deg(idx), 4'b0000}));
	endfunction

	typedef struct packed {
		logic signed [TEMP_W-1:0] direct;
		logic interp;
		logic in_window;
		logic read_ok;
		logic signed [TEMP_W-1:0] base;
		logic neg;
		logic span_zero;
	} meta_t;

endpackage

[rtl/thtemp_ifs.sv]
// Valid/ready channel interfaces for samples and results.
interface thtemp_sample_if import thtemp_pkg::*; ();
	logic valid;
	logic ready;
	logic [OHMS_W-1:0] resistance;
	logic adc_ok;

	modport source(output valid, resistance, adc_ok, input ready);
	modport sink(input valid, resistance, adc_ok, output ready);
endinterface

interface thtemp_result_if import thtemp_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [TEMP_W-1:0] temperature;
	logic in_window;
	logic read_ok;

	modport source(output valid, temperature, in_window, read_ok, input ready);
	modport sink(input valid, temperature, in_window, read_ok, output ready);
endinterface

[rtl/thtemp_front.sv]
// Stages 1 and 2: window check, table compares and segment selection.
module thtemp_front import thtemp_pkg::*; #(
	parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [OHMS_W-1:0] resistance,
	input  logic adc_ok,
	input  logic [OHMS_W-1:0] valid_min,
	input  logic [OHMS_W-1:0] valid_max,
	input  logic signed [TEMP_W-1:0] fault_temp,
	output logic valid_s2,
	output logic [OHMS_W-1:0] r_s2,
	output logic [SEG_W-1:0] seg_s2,
	output meta_t meta_s2
);

	localparam int NPTS = (TABLE_POINTS < 2) ? 2 :
		((TABLE_POINTS > TABLE_CAP) ? TABLE_CAP : TABLE_POINTS);

	logic valid_s1;
	logic [OHMS_W-1:0] r_s1;
	logic ok_s1;
	logic win_s1;
	logic signed [TEMP_W-1:0] fault_s1;
	logic [NPTS-1:0] ge_s1;
	logic le_last_s1;

	logic [NPTS-1:0] ge_c;
	logic [SEG_W-1:0] seg_c;
	meta_t meta_c;

	always_comb begin
		for (int i = 0; i < NPTS; i++) begin
			ge_c[i] = resistance >= tbl_ohms(SEG_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1 <= resistance;
			ok_s1 <= adc_ok;
			win_s1 <= (resistance >= valid_min) && (resistance <= valid_max);
			fault_s1 <= fault_temp;
			ge_s1 <= ge_c;
			le_last_s1 <= resistance <= tbl_ohms(SEG_W'(NPTS - 1));
		end
	end

	// The first segment whose lower point lies at or below the resistance wins.
	always_comb begin
		seg_c = '0;
		for (int i = NPTS - 2; i >= 0; i--) begin
			if (ge_s1[i+1]) begin
				seg_c = SEG_W'(i);
			end
		end
	end

	always_comb begin
		meta_c = '0;
		if (!ok_s1) begin
			meta_c.direct = '0;
		end else if (!win_s1) begin
			meta_c.direct = fault_s1;
			meta_c.read_ok = 1'b1;
		end else begin
			meta_c.in_window = 1'b1;
			meta_c.read_ok = 1'b1;
			if (ge_s1[0]) begin
				meta_c.direct = deg16('0);
			end else if (le_last_s1) begin
				meta_c.direct = deg16(SEG_W'(NPTS - 1));
			end else begin
				meta_c.interp = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2 <= r_s1;
			seg_s2 <= seg_c;
			meta_s2 <= meta_c;
		end
	end

endmodule

[rtl/thtemp_mul.sv]
// Stages 3 and 4: segment lookup, offset and slope product.
module thtemp_mul import thtemp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_s2,
	input  logic [OHMS_W-1:0] r_s2,
	input  logic [SEG_W-1:0] seg_s2,
	input  meta_t meta_s2,
	output logic valid_s4,
	output logic [PROD_W-1:0] prod_s4,
	output logic [OHMS_W-1:0] span_s4,
	output meta_t meta_s4
);

	logic valid_s3;
	logic [OHMS_W-1:0] off_s3;
	logic [MAG_W-1:0] mag_s3;
	logic [OHMS_W-1:0] span_s3;
	meta_t meta_s3;

	logic [SEG_W-1:0] seg_nx;
	logic [OHMS_W-1:0] lo_r;
	logic [OHMS_W-1:0] hi_r;
	logic signed [TEMP_W-1:0] t_lo;
	logic signed [TEMP_W-1:0] t_hi;
	logic signed [TEMP_W:0] dt;
	logic [TEMP_W:0] dt_abs;
	meta_t meta_c;

	always_comb begin
		seg_nx = seg_s2 + SEG_W'(1);
		lo_r = tbl_ohms(seg_nx);
		hi_r = tbl_ohms(seg_s2);
		t_lo = deg16(seg_nx);
		t_hi = deg16(seg_s2);
		dt = {t_lo[TEMP_W-1], t_lo} - {t_hi[TEMP_W-1], t_hi};
		dt_abs = dt[TEMP_W] ? (TEMP_W+1)'(-dt) : dt;
		meta_c = meta_s2;
		meta_c.base = t_lo;
		meta_c.neg = dt[TEMP_W];
		meta_c.span_zero = !(hi_r > lo_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s3 <= r_s2 - lo_r;
			mag_s3 <= dt_abs[MAG_W-1:0];
			span_s3 <= (hi_r > lo_r) ? (hi_r - lo_r) : '0;
			meta_s3 <= meta_c;
			prod_s4 <= PROD_W'(off_s3) * PROD_W'(mag_s3);
			span_s4 <= span_s3;
			meta_s4 <= meta_s3;
		end
	end

endmodule

[rtl/thtemp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module thtemp_div import thtemp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_i,
	input  logic [PROD_W-1:0] prod_i,
	input  logic [OHMS_W-1:0] span_i,
	input  meta_t meta_i,
	output logic valid_o,
	output logic [PROD_W-1:0] quot_o,
	output meta_t meta_o
);

	// Per stage: dividend bits still to consume shift out the top while
	// quotient bits shift in at the bottom.
	logic vld_s [PROD_W];
	logic [PROD_W-1:0] dq_s [PROD_W];
	logic [OHMS_W-1:0] rem_s [PROD_W];
	logic [OHMS_W-1:0] den_s [PROD_W];
	meta_t meta_s [PROD_W];

	for (genvar k = 0; k < PROD_W; k++) begin : g_stage
		logic vld_in;
		logic [PROD_W-1:0] dq_in;
		logic [OHMS_W-1:0] rem_in;
		logic [OHMS_W-1:0] den_in;
		meta_t meta_in;
		logic [OHMS_W:0] trial;
		logic fits;

		if (k == 0) begin : g_first
			assign vld_in = valid_i;
			assign dq_in = prod_i;
			assign rem_in = '0;
			assign den_in = span_i;
			assign meta_in = meta_i;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign dq_in = dq_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign meta_in = meta_s[k-1];
		end

		assign trial = {rem_in, dq_in[PROD_W-1]};
		assign fits = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= fits ? OHMS_W'(trial - {1'b0, den_in}) : trial[OHMS_W-1:0];
				dq_s[k] <= {dq_in[PROD_W-2:0], fits};
				den_s[k] <= den_in;
				meta_s[k] <= meta_in;
			end
		end
	end

	assign valid_o = vld_s[PROD_W-1];
	assign quot_o = dq_s[PROD_W-1];
	assign meta_o = meta_s[PROD_W-1];

endmodule

[rtl/thermistor_ohms_to_temp_interp_core.sv]
// A result passes 4 front stages, 28 divider stages and the output register after its sample
// is taken; one sample per cycle is sustained while the output is not stalled.
// The 28-stage quotient pipeline sets the latency; a stalled output freezes all stages.
// Reset (arst_n low) clears every valid bit at once and loads the register
// defaults: window 40..30000 ohms, minimum temperature -640 sixteenths.
`include "thermistor_ohms_to_temp_interp_core_defines.svh"

module thermistor_ohms_to_temp_interp_core import thtemp_pkg::*; #(
	parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [OHMS_W-1:0] cfg_wdata,
	thtemp_sample_if.sink sample,
	thtemp_result_if.source result
);

	localparam int ACC_W = PROD_W + 2;
	localparam logic signed [ACC_W-1:0] ACC_HI = signed'(ACC_W'(TEMP_HI));
	localparam logic signed [ACC_W-1:0] ACC_LO = signed'(ACC_W'(TEMP_LO));

	logic [OHMS_W-1:0] valid_min_q;
	logic [OHMS_W-1:0] valid_max_q;
	logic signed [TEMP_W-1:0] min_temp_q;

	logic adv;
	logic signed [TEMP_W:0] fault_wide;
	logic signed [TEMP_W-1:0] fault_temp;

	logic valid_s2;
	logic [OHMS_W-1:0] r_s2;
	logic [SEG_W-1:0] seg_s2;
	meta_t meta_s2;

	logic valid_s4;
	logic [PROD_W-1:0] prod_s4;
	logic [OHMS_W-1:0] span_s4;
	meta_t meta_s4;

	logic div_valid;
	logic [PROD_W-1:0] quot;
	meta_t div_meta;

	logic signed [ACC_W-1:0] q_ext;
	logic signed [ACC_W-1:0] base_ext;
	logic signed [ACC_W-1:0] acc;
	logic signed [TEMP_W-1:0] interp_temp;

	logic out_valid_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic in_window_q;
	logic read_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_min_q <= RST_VALID_MIN;
			valid_max_q <= RST_VALID_MAX;
			min_temp_q <= RST_MIN_TEMP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VALID_MIN: valid_min_q <= cfg_wdata;
				REG_VALID_MAX: valid_max_q <= cfg_wdata;
				REG_MIN_TEMP: min_temp_q <= signed'(cfg_wdata[TEMP_W-1:0]);
				default: ;
			endcase
		end
	end

	// Only the low side can overflow after the offset is taken off.
	always_comb begin
		fault_wide = {min_temp_q[TEMP_W-1], min_temp_q} - (TEMP_W+1)'(FAULT_OFFSET);
		fault_temp = (fault_wide[TEMP_W] != fault_wide[TEMP_W-1]) ? TEMP_MIN
			: fault_wide[TEMP_W-1:0];
	end

	assign adv = !out_valid_q || result.ready;
	assign sample.ready = adv;

	thtemp_front #(
		.TABLE_POINTS(TABLE_POINTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(sample.valid),
		.resistance(sample.resistance),
		.adc_ok(sample.adc_ok),
		.valid_min(valid_min_q),
		.valid_max(valid_max_q),
		.fault_temp(fault_temp),
		.valid_s2(valid_s2),
		.r_s2(r_s2),
		.seg_s2(seg_s2),
		.meta_s2(meta_s2)
	);

	thtemp_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_s2(valid_s2),
		.r_s2(r_s2),
		.seg_s2(seg_s2),
		.meta_s2(meta_s2),
		.valid_s4(valid_s4),
		.prod_s4(prod_s4),
		.span_s4(span_s4),
		.meta_s4(meta_s4)
	);

	thtemp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_i(valid_s4),
		.prod_i(prod_s4),
		.span_i(span_s4),
		.meta_i(meta_s4),
		.valid_o(div_valid),
		.quot_o(quot),
		.meta_o(div_meta)
	);

	// A falling segment adds the quotient, a rising one subtracts it.
	always_comb begin
		q_ext = div_meta.span_zero ? '0 : signed'({2'b00, quot});
		base_ext = ACC_W'(div_meta.base);
		acc = div_meta.neg ? (base_ext + q_ext) : (base_ext - q_ext);
		if (acc > ACC_HI) begin
			interp_temp = TEMP_MAX;
		end else if (acc < ACC_LO) begin
			interp_temp = TEMP_MIN;
		end else begin
			interp_temp = acc[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_q <= div_meta.interp ? interp_temp : div_meta.direct;
			in_window_q <= div_meta.in_window;
			read_ok_q <= div_meta.read_ok;
		end
	end

	assign result.valid = out_valid_q;
	assign result.temperature = temp_q;
	assign result.in_window = in_window_q;
	assign result.read_ok = read_ok_q;

	`THTEMP_ASSERT_IMP(a_fail_zero, out_valid_q && !read_ok_q, (temp_q == '0) && !in_window_q, "failed read not cleared")
	`THTEMP_ASSERT_IMP(a_valid_needs_ok, out_valid_q && in_window_q, read_ok_q, "in window without a good read")
	`THTEMP_ASSERT_IMP(a_stall_blocks_input, out_valid_q && !result.ready, !sample.ready, "input taken in a stall")
	`THTEMP_ASSERT_NXT(a_div_to_out, div_valid && adv, out_valid_q, "divider result lost")

endmodule
